// ===== hdl/glitch_pulse_arm_fire_sequencer_core_defines.svh =====
// Assertion macros used by the checker file of the sequencer core.
`ifndef GLITCH_PULSE_ARM_FIRE_SEQUENCER_CORE_DEFINES_SVH
`define GLITCH_PULSE_ARM_FIRE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPAFS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPAFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gpafs_pkg.sv =====
// ----------------------------------------------------------------------------
// gpafs_pkg
// Types and constants of the glitch pulse arm/fire sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package gpafs_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_ARMING  = 3'd1,
        MODE_CHARGED = 3'd2,
        MODE_WAITING = 3'd3,
        MODE_FIRED   = 3'd4,
        MODE_ERROR   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        FAULT_NONE       = 3'd0,
        FAULT_BAD_CONFIG = 3'd1,
        FAULT_HV         = 3'd2,
        FAULT_ENGINE     = 3'd3,
        FAULT_TIMEOUT    = 3'd4
    } fault_t;

    // Request codes; codes above REQ_TICK are ignored
    localparam logic [2:0] REQ_COMMIT = 3'd0;
    localparam logic [2:0] REQ_ARM    = 3'd1;
    localparam logic [2:0] REQ_FIRE   = 3'd2;
    localparam logic [2:0] REQ_DISARM = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PULSE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_PULSE_DELAY    = 2'd1;
    localparam logic [1:0] CFG_TRIGGER_MODE   = 2'd2;
    localparam logic [1:0] CFG_CHARGE_TIMEOUT = 2'd3;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [5:0]  MIN_WIDTH_US   = 6'd1;
    localparam logic [5:0]  MAX_WIDTH_US   = 6'd50;
    localparam logic [19:0] MAX_DELAY_US   = 20'd1000000;
    localparam logic [31:0] STALE_LIMIT_MS = 32'd100;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] trig_wait_ms;
        logic        hv_charged;
        logic        engine_ok;
        logic        engine_done;
        logic [15:0] capture_count;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  mode;
        logic [2:0]  fault_code;
        logic        do_teardown;
        logic        do_charge;
        logic        do_start_pulse;
        logic [15:0] fired_capture_count;
        logic [5:0]  fired_width_us;
        logic [19:0] fired_delay_us;
        logic [31:0] fired_at_ms;
    } out_item_t;

    typedef struct packed {
        logic [5:0]  pulse_width_us;
        logic [19:0] pulse_delay_us;
        logic [31:0] charge_window_ms;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        fault_t      fault;
        logic        setup_valid;
        logic [31:0] arm_start_ms;
        logic [31:0] fire_start_ms;
        logic [31:0] fire_limit_ms;
        logic [31:0] last_charged_ms;
        logic [15:0] rec_capture_count;
        logic [5:0]  rec_width_us;
        logic [19:0] rec_delay_us;
        logic [31:0] rec_fired_ms;
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/gpafs_step.sv =====
// ----------------------------------------------------------------------------
// gpafs_step
// Next-state and result logic for one request of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gpafs_step (
    input  wire gpafs_pkg::state_t    cur,
    input  wire gpafs_pkg::in_item_t  req,
    input  wire gpafs_pkg::cfg_t      cfg,
    output gpafs_pkg::state_t         nxt,
    output gpafs_pkg::out_item_t      res
);

    logic        acc;
    logic        tear;
    logic        chg;
    logic        start;
    logic [31:0] charged_age;
    logic [31:0] arm_age;
    logic [31:0] fire_age;
    logic        cfg_ok;
    logic        stale;

    assign charged_age = req.now_ms - cur.last_charged_ms;
    assign arm_age     = req.now_ms - cur.arm_start_ms;
    assign fire_age    = req.now_ms - cur.fire_start_ms;
    assign stale       = charged_age > gpafs_pkg::STALE_LIMIT_MS;
    assign cfg_ok      = (cfg.pulse_width_us >= gpafs_pkg::MIN_WIDTH_US) &&
                         (cfg.pulse_width_us <= gpafs_pkg::MAX_WIDTH_US) &&
                         (cfg.pulse_delay_us <= gpafs_pkg::MAX_DELAY_US);

    always_comb begin
        nxt   = cur;
        acc   = 1'b0;
        tear  = 1'b0;
        chg   = 1'b0;
        start = 1'b0;
        case (req.req_type)
            gpafs_pkg::REQ_COMMIT: begin
                if (cfg_ok) begin
                    nxt.setup_valid = 1'b1;
                    nxt.mode        = gpafs_pkg::MODE_IDLE;
                    nxt.fault       = gpafs_pkg::FAULT_NONE;
                    acc             = 1'b1;
                end
            end
            gpafs_pkg::REQ_ARM: begin
                if (!cur.setup_valid) begin
                    tear      = 1'b1;
                    nxt.mode  = gpafs_pkg::MODE_ERROR;
                    nxt.fault = gpafs_pkg::FAULT_BAD_CONFIG;
                end else if (cur.mode == gpafs_pkg::MODE_IDLE) begin
                    chg              = 1'b1;
                    nxt.arm_start_ms = req.now_ms;
                    nxt.mode         = gpafs_pkg::MODE_ARMING;
                    nxt.fault        = gpafs_pkg::FAULT_NONE;
                    acc              = 1'b1;
                end
            end
            gpafs_pkg::REQ_FIRE: begin
                if (cur.mode == gpafs_pkg::MODE_CHARGED) begin
                    // resample a stale charged status; the refresh sticks even on engine fault
                    if (stale && req.hv_charged) begin
                        nxt.last_charged_ms = req.now_ms;
                    end
                    if (stale && !req.hv_charged) begin
                        tear      = 1'b1;
                        nxt.mode  = gpafs_pkg::MODE_ERROR;
                        nxt.fault = gpafs_pkg::FAULT_HV;
                    end else if (!req.engine_ok) begin
                        tear      = 1'b1;
                        nxt.mode  = gpafs_pkg::MODE_ERROR;
                        nxt.fault = gpafs_pkg::FAULT_ENGINE;
                    end else begin
                        nxt.fire_start_ms = req.now_ms;
                        nxt.fire_limit_ms = req.trig_wait_ms;
                        nxt.mode          = gpafs_pkg::MODE_WAITING;
                        start             = 1'b1;
                        acc               = 1'b1;
                    end
                end
            end
            gpafs_pkg::REQ_DISARM: begin
                tear                  = 1'b1;
                nxt.mode              = gpafs_pkg::MODE_IDLE;
                nxt.fault             = gpafs_pkg::FAULT_NONE;
                nxt.rec_capture_count = '0;
                nxt.rec_width_us      = '0;
                nxt.rec_delay_us      = '0;
                nxt.rec_fired_ms      = '0;
                acc                   = 1'b1;
            end
            gpafs_pkg::REQ_TICK: begin
                acc = 1'b1;
                case (cur.mode)
                    gpafs_pkg::MODE_ARMING: begin
                        if (req.hv_charged) begin
                            nxt.mode            = gpafs_pkg::MODE_CHARGED;
                            nxt.last_charged_ms = req.now_ms;
                        end else if ((cfg.charge_window_ms != '0) &&
                                     (arm_age > cfg.charge_window_ms)) begin
                            tear      = 1'b1;
                            nxt.mode  = gpafs_pkg::MODE_ERROR;
                            nxt.fault = gpafs_pkg::FAULT_HV;
                        end
                    end
                    gpafs_pkg::MODE_CHARGED: begin
                        if (req.hv_charged) begin
                            nxt.last_charged_ms = req.now_ms;
                        end
                    end
                    gpafs_pkg::MODE_WAITING: begin
                        if (req.engine_done) begin
                            nxt.rec_capture_count = req.capture_count;
                            nxt.rec_width_us      = cfg.pulse_width_us;
                            nxt.rec_delay_us      = cfg.pulse_delay_us;
                            nxt.rec_fired_ms      = req.now_ms;
                            tear                  = 1'b1;
                            nxt.mode              = gpafs_pkg::MODE_FIRED;
                        end else if ((cur.fire_limit_ms != '0) &&
                                     (fire_age > cur.fire_limit_ms)) begin
                            tear      = 1'b1;
                            nxt.mode  = gpafs_pkg::MODE_ERROR;
                            nxt.fault = gpafs_pkg::FAULT_TIMEOUT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.accepted            = acc;
        res.mode                = nxt.mode;
        res.fault_code          = nxt.fault;
        res.do_teardown         = tear;
        res.do_charge           = chg;
        res.do_start_pulse      = start;
        res.fired_capture_count = nxt.rec_capture_count;
        res.fired_width_us      = nxt.rec_width_us;
        res.fired_delay_us      = nxt.rec_delay_us;
        res.fired_at_ms         = nxt.rec_fired_ms;
    end

endmodule

`default_nettype wire

// ===== hdl/glitch_pulse_arm_fire_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// glitch_pulse_arm_fire_sequencer_core
// Fault-injection campaign sequencer: commit, arm, fire, disarm and tick.
// ----------------------------------------------------------------------------
// Takes one request per clock while results are taken and returns exactly
// one result per request: the request lands in an input register, the
// whole state update runs through one pass of compare and subtract logic,
// and the result lands in an output register. The rate is one request per
// cycle while the output is not stalled, set by the single state register
// that every request reads and writes. A stalled result holds in the output
// register while the next request waits in the input register.
// Configuration registers are read live; the trigger mode register is
// accepted on the port but feeds no output of this core.
`default_nettype none

module glitch_pulse_arm_fire_sequencer_core (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire gpafs_pkg::in_item_t               s_data,
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output gpafs_pkg::out_item_t                   m_data,
    input  wire                                    cfg_wr_en,
    input  wire  [gpafs_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire  [gpafs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    logic                  in_vld_reg;
    gpafs_pkg::in_item_t   in_item_reg;
    logic                  out_vld_reg;
    gpafs_pkg::out_item_t  out_item_reg;
    gpafs_pkg::state_t     state_reg;
    gpafs_pkg::state_t     state_next;
    gpafs_pkg::out_item_t  out_item_next;
    gpafs_pkg::cfg_t       cfg_reg;
    logic                  advance;

    // Process the held transaction when the result slot is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_data  = out_item_reg;

    gpafs_step u_step (
        .cur (state_reg),
        .req (in_item_reg),
        .cfg (cfg_reg),
        .nxt (state_next),
        .res (out_item_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gpafs_pkg::CFG_PULSE_WIDTH:    cfg_reg.pulse_width_us   <= cfg_wdata[5:0];
                gpafs_pkg::CFG_PULSE_DELAY:    cfg_reg.pulse_delay_us   <= cfg_wdata[19:0];
                gpafs_pkg::CFG_CHARGE_TIMEOUT: cfg_reg.charge_window_ms <= cfg_wdata;
                // trigger mode feeds no output of this core; drop it here
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode              <= gpafs_pkg::MODE_IDLE;
            state_reg.fault             <= gpafs_pkg::FAULT_NONE;
            state_reg.setup_valid       <= 1'b0;
            state_reg.arm_start_ms      <= '0;
            state_reg.fire_start_ms     <= '0;
            state_reg.fire_limit_ms     <= '0;
            state_reg.last_charged_ms   <= '0;
            state_reg.rec_capture_count <= '0;
            state_reg.rec_width_us      <= '0;
            state_reg.rec_delay_us      <= '0;
            state_reg.rec_fired_ms      <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gpafs_checker.sv =====
// ----------------------------------------------------------------------------
// gpafs_checker
// Port-level assertions for the sequencer core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glitch_pulse_arm_fire_sequencer_core_defines.svh"

module gpafs_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        m_valid,
    input wire                        m_ready,
    input wire gpafs_pkg::out_item_t  m_data
);

    logic fault_set;
    logic in_error;

    assign fault_set = m_data.fault_code != gpafs_pkg::FAULT_NONE;
    assign in_error  = m_data.mode == gpafs_pkg::MODE_ERROR;

    // A stalled result holds until taken
    `GPAFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")

    // A fault is reported exactly when the campaign sits in error
    `GPAFS_ASSERT_NOW(a_fault_mode, aclk, aresetn, m_valid, fault_set == in_error, "fault code and error mode disagree")

    // Charging starts only on an accepted arm that leaves the block arming
    `GPAFS_ASSERT_NOW(a_charge, aclk, aresetn, m_valid && m_data.do_charge, m_data.accepted && (m_data.mode == gpafs_pkg::MODE_ARMING) && !m_data.do_teardown, "charge pulse outside a clean arm")

    // Pulse start only on an accepted fire that leaves the block waiting
    `GPAFS_ASSERT_NOW(a_start, aclk, aresetn, m_valid && m_data.do_start_pulse, m_data.accepted && (m_data.mode == gpafs_pkg::MODE_WAITING) && !m_data.do_teardown && !m_data.do_charge, "start pulse outside a clean fire")

endmodule

bind glitch_pulse_arm_fire_sequencer_core gpafs_checker u_gpafs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
